/* rtl/lks_pkg.sv */
// Shared types and constants for the LRU key set.
package lks_pkg;

  localparam int unsigned OUT_KEY_BITS = 32;
  localparam int unsigned OCC_BITS     = 4;

  typedef enum logic [0:0] {
    CMD_PUT   = 1'b0,
    CMD_FETCH = 1'b1
  } lks_cmd_t;

  typedef struct packed {
    logic                    hit;
    logic [OUT_KEY_BITS-1:0] front_key;
    logic [OUT_KEY_BITS-1:0] back_key;
    logic [OCC_BITS-1:0]     occupancy;
    logic                    evicted;
    logic [OUT_KEY_BITS-1:0] evicted_key;
  } lks_result_t;

endpackage

/* rtl/lks_match.sv */
// Parallel key compare across all occupied slots.
module lks_match import lks_pkg::*; #(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned CW        = $clog2(ENTRIES + 1)
) (
  input  logic [KEY_WIDTH-1:0] slots [ENTRIES],
  input  logic [CW-1:0]        count,
  input  logic [KEY_WIDTH-1:0] key,
  output logic [ENTRIES-1:0]   match,
  output logic [ENTRIES-1:0]   at_or_before
);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (CW'(i) < count) && (slots[i] == key);
    end
  end

  // Slot i lies at or before the hit position when a match sits at i or later.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      at_or_before[i] = |(match >> i);
    end
  end

endmodule

/* rtl/lks_core.sv */
// Recency-ordered key slots, occupancy count and result formation.
module lks_core import lks_pkg::*; #(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  lks_cmd_t             cmd,
  input  logic [KEY_WIDTH-1:0] key,
  output lks_result_t          result
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [KEY_WIDTH-1:0] slot_r   [ENTRIES];
  logic [KEY_WIDTH-1:0] slot_nxt [ENTRIES];
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   at_or_before;
  logic                 hit;
  logic                 put_miss;
  logic                 full;
  logic [KEY_WIDTH-1:0] back_w;

  function automatic logic [OUT_KEY_BITS-1:0] to_out(logic [KEY_WIDTH-1:0] k);
    logic [KEY_WIDTH+OUT_KEY_BITS-1:0] e;
    e = {{OUT_KEY_BITS{1'b0}}, k};
    return e[OUT_KEY_BITS-1:0];
  endfunction

  function automatic logic [OCC_BITS-1:0] to_occ(logic [CW-1:0] c);
    logic [CW+OCC_BITS-1:0] e;
    e = {{OCC_BITS{1'b0}}, c};
    return e[OCC_BITS-1:0];
  endfunction

  lks_match #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH),
    .CW        (CW)
  ) u_match (
    .slots        (slot_r),
    .count        (count_r),
    .key          (key),
    .match        (match),
    .at_or_before (at_or_before)
  );

  assign hit      = |match;
  assign put_miss = !hit && (cmd == CMD_PUT);
  assign full     = (count_r == CW'(ENTRIES));

  always_comb begin
    slot_nxt  = slot_r;
    count_nxt = count_r;
    if (hit || put_miss) begin
      slot_nxt[0] = key;
      for (int i = 1; i < ENTRIES; i++) begin
        if (put_miss || at_or_before[i]) begin
          slot_nxt[i] = slot_r[i-1];
        end
      end
    end
    if (put_miss && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    back_w = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (CW'(i + 1) == count_nxt) begin
        back_w = slot_nxt[i];
      end
    end
  end

  always_comb begin
    result.hit         = hit;
    result.front_key   = (count_nxt != '0) ? to_out(slot_nxt[0]) : '0;
    result.back_key    = to_out(back_w);
    result.occupancy   = to_occ(count_nxt);
    result.evicted     = put_miss && full;
    result.evicted_key = (put_miss && full) ? to_out(slot_r[ENTRIES-1]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      slot_r <= slot_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("occupancy beyond capacity");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && hit |=> count_r == $past(count_r))
    else $error("hit changed occupancy");

  a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.evicted |-> full && !hit && cmd == CMD_PUT)
    else $error("eviction without full put miss");

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("duplicate key held");

endmodule

/* rtl/lru_key_set.sv */
// Top level of the LRU key set: input register, core and result register.
// Holds up to ENTRIES keys in recency order. Each command (put or fetch) yields
// one result item. The accepting edge loads the input register; once the
// result register is free, the compare and shift run and the result register
// is loaded. The parallel compare and the slot shift are combinational, so a
// new item is accepted every cycle unless the result register is held, and
// the state seen by an item already includes every earlier item. The only
// stall is a held result register while out_ready is low.
module lru_key_set import lks_pkg::*; #(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [OUT_KEY_BITS-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic [OUT_KEY_BITS-1:0] out_front_key,
  output logic [OUT_KEY_BITS-1:0] out_back_key,
  output logic [OCC_BITS-1:0]     out_occupancy,
  output logic                    out_evicted,
  output logic [OUT_KEY_BITS-1:0] out_evicted_key
);

  logic                                inq_valid_r;
  lks_cmd_t                            inq_cmd_r;
  logic [KEY_WIDTH-1:0]                inq_key_r;
  logic [KEY_WIDTH+OUT_KEY_BITS-1:0]   key_ext;
  logic                                out_valid_r;
  lks_result_t                         res_r;
  lks_result_t                         res_w;
  logic                                advance;

  assign advance  = inq_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !inq_valid_r || advance;
  assign key_ext  = {{KEY_WIDTH{1'b0}}, in_key};

  lks_core #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .cmd    (inq_cmd_r),
    .key    (inq_key_r),
    .result (res_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        inq_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_cmd_r <= lks_cmd_t'(in_command);
      inq_key_r <= key_ext[KEY_WIDTH-1:0];
    end
    if (advance) begin
      res_r <= res_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = res_r.hit;
  assign out_front_key   = res_r.front_key;
  assign out_back_key    = res_r.back_key;
  assign out_occupancy   = res_r.occupancy;
  assign out_evicted     = res_r.evicted;
  assign out_evicted_key = res_r.evicted_key;

endmodule
